>>> hdl/mbss_pkg.sv
// Shared types, constants and register map of the masked byte signature scan.
`default_nettype none

package mbss_pkg;

    localparam int unsigned MBSS_PATTERN_MAX  = 32;
    localparam int unsigned MBSS_ADDRESS_BITS = 32;

    // Signature bytes held in the registers.
    localparam int unsigned SIG_BYTES  = 32;
    localparam int unsigned SIG_IDX_W  = $clog2(SIG_BYTES);

    localparam int unsigned APB_ADDR_W = 6;
    localparam int unsigned APB_DATA_W = 64;

    typedef enum logic [2:0] {
        REG_PATTERN0 = 3'd0,
        REG_PATTERN1 = 3'd1,
        REG_PATTERN2 = 3'd2,
        REG_PATTERN3 = 3'd3,
        REG_CARE     = 3'd4,
        REG_LENGTH   = 3'd5,
        REG_BASE     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [3:0][63:0] pattern_word;
        logic [31:0]      care_mask;
        logic [5:0]       pattern_length;
        logic [31:0]      base_address;
    } cfg_t;

endpackage

`default_nettype wire

>>> hdl/mbss_if.sv
// Item channels of the masked byte signature scan.
`default_nettype none

interface mbss_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbss_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [31:0] match_address;

    modport source (output valid, output found, output match_address, input ready);
    modport sink   (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

>>> hdl/masked_byte_signature_scan_top.sv
// Masked byte signature scan: top level with cell chain, scan control and result queue.
//
// Bytes of a memory region arrive on in_ch, one per item, the final byte flagged
// by last_byte. A row of PATTERN_MAX cells shifts the bytes along and each cell
// compares its input byte with its signature byte; the hits are combined in the cycle
// the byte is accepted. The first match pushes one item (found = 1, base address
// plus start offset) onto out_ch; a region that ends with no match pushes one
// item with found = 0. Scan state clears after the last byte.
// Throughput: one byte per cycle while in_ch.ready is high. A result is written
// into the result queue and shows on out_ch once it reaches the queue head.
// A two-entry result queue sits before out_ch, so input keeps flowing while a
// result waits; in_ch.ready drops only when both entries are full.
// Configuration goes through the APB port; register i sits at byte address 8*i,
// writes take effect for the next byte. Reset clears the scan state, empties the
// queue and sets registers to zero, pattern_length to 1.
`default_nettype none

module masked_byte_signature_scan_top
    import mbss_pkg::*;
#(
    parameter int unsigned PATTERN_MAX  = MBSS_PATTERN_MAX,
    parameter int unsigned ADDRESS_BITS = MBSS_ADDRESS_BITS
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mbss_in_if.sink                    in_ch,
    mbss_out_if.source                 out_ch,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int unsigned LW = $clog2(PATTERN_MAX + 1);
    localparam logic [31:0] ADDR_MASK = (ADDRESS_BITS >= 32) ? 32'hFFFF_FFFF
                                      : 32'((64'd1 << ADDRESS_BITS) - 64'd1);

    cfg_t cfg;

    mbss_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // effective length
    logic [6:0]    len_wide;
    logic [6:0]    len_clamp;
    logic [LW-1:0] len_eff;

    assign len_wide = {1'b0, cfg.pattern_length};

    always_comb
    begin
        if (len_wide == 7'd0)
        begin
            len_clamp = 7'd1;
        end
        else if (len_wide > 7'(PATTERN_MAX))
        begin
            len_clamp = 7'(PATTERN_MAX);
        end
        else
        begin
            len_clamp = len_wide;
        end
    end

    assign len_eff = LW'(len_clamp);

    // cell chain
    logic                        accept;
    logic [PATTERN_MAX-1:0][7:0] cell_in;
    logic [PATTERN_MAX-1:0]      cell_hit;

    assign accept     = in_ch.valid && in_ch.ready;
    assign cell_in[0] = in_ch.data_byte;

    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        if (k < PATTERN_MAX - 1)
        begin : g_mid
            mbss_cell #(
                .INDEX       (k),
                .PATTERN_MAX (PATTERN_MAX),
                .LW          (LW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (accept),
                .clear    (in_ch.last_byte),
                .byte_in  (cell_in[k]),
                .cfg      (cfg),
                .len_eff  (len_eff),
                .byte_out (cell_in[k+1]),
                .hit      (cell_hit[k])
            );
        end
        else
        begin : g_end
            mbss_cell #(
                .INDEX       (k),
                .PATTERN_MAX (PATTERN_MAX),
                .LW          (LW)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift    (accept),
                .clear    (in_ch.last_byte),
                .byte_in  (cell_in[k]),
                .cfg      (cfg),
                .len_eff  (len_eff),
                .byte_out (),
                .hit      (cell_hit[k])
            );
        end
    end

    // scan control
    logic [31:0] seen_reg;
    logic [31:0] seen_next;
    logic [31:0] seen_inc;
    logic        found_reg;
    logic        found_next;
    logic        match;
    logic [31:0] offset;
    logic        push;
    logic        push_found;
    logic [31:0] push_addr;

    assign seen_inc   = (seen_reg == 32'hFFFF_FFFF) ? seen_reg : seen_reg + 32'd1;
    assign match      = !found_reg && (seen_inc >= 32'(len_eff)) && (&cell_hit);
    assign offset     = seen_inc - 32'(len_eff);
    assign push_found = match;
    assign push_addr  = match ? ((cfg.base_address + offset) & ADDR_MASK) : 32'd0;
    assign push       = accept && (match || (in_ch.last_byte && !found_reg));

    always_comb
    begin
        seen_next  = seen_reg;
        found_next = found_reg;
        if (accept)
        begin
            if (in_ch.last_byte)
            begin
                seen_next  = 32'd0;
                found_next = 1'b0;
            end
            else
            begin
                seen_next  = seen_inc;
                found_next = found_reg || match;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= 32'd0;
            found_reg <= 1'b0;
        end
        else
        begin
            seen_reg  <= seen_next;
            found_reg <= found_next;
        end
    end

    // result queue
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic        pop;
    logic [1:0]  q_found_reg;
    logic [31:0] q_addr_reg [2];

    assign in_ch.ready          = (cnt_reg != 2'd2);
    assign pop                  = out_ch.valid && out_ch.ready;
    assign out_ch.valid         = (cnt_reg != 2'd0);
    assign out_ch.found         = q_found_reg[rd_ptr_reg];
    assign out_ch.match_address = q_addr_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_found_reg[wr_ptr_reg] <= push_found;
            q_addr_reg[wr_ptr_reg]  <= push_addr;
        end
    end

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_ch.last_byte |=> (seen_reg == 32'd0) && !found_reg)
        else $error("scan state not cleared after last byte");

    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_found |-> !found_reg)
        else $error("second match reported in one scan");

    a_miss_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        push && !push_found |-> in_ch.last_byte && !found_reg)
        else $error("not-found item outside the last byte");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'd2)
        else $error("result queue count out of range");

endmodule

`default_nettype wire

>>> hdl/mbss_regs.sv
// APB configuration registers of the masked byte signature scan.
`default_nettype none

module mbss_regs
    import mbss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{pattern_word:   '0,
                         care_mask:      32'd0,
                         pattern_length: 6'd1,
                         base_address:   32'd0};
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PATTERN0: cfg_reg.pattern_word[0] <= pwdata;
                REG_PATTERN1: cfg_reg.pattern_word[1] <= pwdata;
                REG_PATTERN2: cfg_reg.pattern_word[2] <= pwdata;
                REG_PATTERN3: cfg_reg.pattern_word[3] <= pwdata;
                REG_CARE:     cfg_reg.care_mask       <= pwdata[31:0];
                REG_LENGTH:   cfg_reg.pattern_length  <= pwdata[5:0];
                REG_BASE:     cfg_reg.base_address    <= pwdata[31:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PATTERN0: prdata = cfg_reg.pattern_word[0];
            REG_PATTERN1: prdata = cfg_reg.pattern_word[1];
            REG_PATTERN2: prdata = cfg_reg.pattern_word[2];
            REG_PATTERN3: prdata = cfg_reg.pattern_word[3];
            REG_CARE:     prdata = {32'd0, cfg_reg.care_mask};
            REG_LENGTH:   prdata = {58'd0, cfg_reg.pattern_length};
            REG_BASE:     prdata = {32'd0, cfg_reg.base_address};
            default:      prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/mbss_cell.sv
// One window cell: holds a byte, passes it on, compares its input byte with its signature byte.
`default_nettype none

module mbss_cell
    import mbss_pkg::*;
#(
    parameter int unsigned INDEX       = 0,
    parameter int unsigned PATTERN_MAX = MBSS_PATTERN_MAX,
    parameter int unsigned LW          = $clog2(PATTERN_MAX + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          shift,
    input  wire logic          clear,
    input  wire logic [7:0]    byte_in,
    input  wire cfg_t          cfg,
    input  wire logic [LW-1:0] len_eff,
    output logic      [7:0]    byte_out,
    output logic               hit
);

    logic [7:0]                 byte_reg;
    logic [7:0]                 byte_next;
    logic [SIG_BYTES-1:0][7:0]  sig_bytes;
    logic [LW-1:0]              sel;
    logic [SIG_IDX_W-1:0]       sig_idx;
    logic                       active;
    logic                       care;

    assign sig_bytes = cfg.pattern_word;
    assign active    = len_eff > LW'(INDEX);
    assign sel       = len_eff - LW'(INDEX) - LW'(1);
    assign sig_idx   = SIG_IDX_W'(sel);
    // signature bytes past the register set are wildcards
    assign care      = (32'(sel) < SIG_BYTES) && cfg.care_mask[sig_idx];
    assign hit       = !active || !care || (byte_in == sig_bytes[sig_idx]);

    assign byte_next = clear ? 8'd0 : byte_in;
    assign byte_out  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else if (shift)
        begin
            byte_reg <= byte_next;
        end
    end

endmodule

`default_nettype wire
